FILE: hdl/pdd_pkg.sv
// Shared types and constants of the pivot divergence detector.
package pdd_pkg;

   localparam int SAMPLE_W = 24;
   localparam int POS_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_SPAN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_SPAN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP    = 2'd2;

   localparam logic [5:0]  LEFT_SPAN_RESET  = 6'd2;
   localparam logic [5:0]  RIGHT_SPAN_RESET = 6'd2;
   localparam logic [15:0] MAX_GAP_RESET    = 16'd200;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] primary_sample;
      logic                       primary_ok;
      logic signed [SAMPLE_W-1:0] secondary_sample;
      logic                       secondary_ok;
   } req_type;

   typedef struct packed {
      logic bullish;
      logic bearish;
      logic low_found;
      logic high_found;
   } rsp_type;

   // One window entry: both series with their valid bits.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] primary;
      logic                       primary_ok;
      logic signed [SAMPLE_W-1:0] secondary;
      logic                       secondary_ok;
   } win_entry_type;

   typedef struct packed {
      logic                       present;
      logic [POS_W-1:0]           pos;
      logic signed [SAMPLE_W-1:0] primary;
      logic signed [SAMPLE_W-1:0] secondary;
      logic                       secondary_ok;
   } pivot_rec_type;

   // Outcome of one pivot test, handed from the scanner to the tracker.
   typedef struct packed {
      logic                       fire;
      logic                       low;
      logic                       high;
      logic [POS_W-1:0]           pos;
      logic signed [SAMPLE_W-1:0] primary;
      logic signed [SAMPLE_W-1:0] secondary;
      logic                       secondary_ok;
   } pivot_evt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SCAN,
      ST_LAST,
      ST_DECIDE
   } pdd_state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CENTER,
      RD_NEIGHBOR
   } rd_kind_type;

endpackage

FILE: hdl/pdd_window_mem.sv
// Sample window memory: one write port, one registered read port.
module pdd_window_mem #(
   parameter int DEPTH = 65,
   parameter int AW    = 7
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  pdd_pkg::win_entry_type wdata,
   input  logic [AW-1:0]          raddr,
   output pdd_pkg::win_entry_type rdata
);
   import pdd_pkg::*;

   win_entry_type mem [DEPTH];
   win_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/pdd_scan.sv
// Window sequencer: stores each item and, once left+right+1 items have arrived, scans the window for a pivot.
module pdd_scan #(
   parameter int MAX_LEFT  = 32,
   parameter int MAX_RIGHT = 32,
   parameter int DEPTH     = MAX_LEFT + MAX_RIGHT + 1,
   parameter int AW        = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pdd_pkg::req_type       req_data,
   input  logic [5:0]             left_span,
   input  logic [5:0]             right_span,
   input  logic                   out_free,
   output logic                   mem_we,
   output logic [AW-1:0]          mem_waddr,
   output pdd_pkg::win_entry_type mem_wdata,
   output logic [AW-1:0]          mem_raddr,
   input  pdd_pkg::win_entry_type mem_rdata,
   output pdd_pkg::pivot_evt_type evt
);
   import pdd_pkg::*;

   pdd_state_type     state_ff, state_in;
   rd_kind_type       rd_kind_ff, rd_kind_in;
   logic [AW-1:0]     rd_k_ff, rd_k_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [POS_W-1:0]  count_ff, count_in;
   logic [AW-1:0]     r_ff, r_in;
   logic [AW-1:0]     span_ff, span_in;
   logic [AW-1:0]     k_ff, k_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   win_entry_type     ctr_ff, ctr_in;
   logic              low_ok_ff, low_ok_in;
   logic              high_ok_ff, high_ok_in;
   logic              tested_ff, tested_in;

   logic [AW-1:0]     l_clamp, r_clamp, head_inc, sel_k;
   logic [POS_W-1:0]  count_inc;

   function automatic logic [AW-1:0] clamp_span(input logic [5:0] v, input int hi);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         v32 = 32'd1;
      end else if (v32 > 32'(hi)) begin
         v32 = 32'(hi);
      end
      return AW'(v32);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_kind_ff <= RD_NONE;
         head_ff    <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rd_kind_ff <= rd_kind_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_k_ff    <= rd_k_in;
      r_ff       <= r_in;
      span_ff    <= span_in;
      k_ff       <= k_in;
      pos_ff     <= pos_in;
      ctr_ff     <= ctr_in;
      low_ok_ff  <= low_ok_in;
      high_ok_ff <= high_ok_in;
      tested_ff  <= tested_in;
   end

   always_comb begin
      l_clamp   = clamp_span(left_span, MAX_LEFT);
      r_clamp   = clamp_span(right_span, MAX_RIGHT);
      head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      count_inc = (count_ff == '1) ? count_ff : count_ff + POS_W'(1);
      sel_k     = (state_ff == ST_CENTER) ? r_ff : k_ff;
      // Entry sel_k items back from the newest one, wrapped into the ring.
      if (head_ff >= sel_k) begin
         mem_raddr = head_ff - sel_k;
      end else begin
         mem_raddr = AW'({1'b0, head_ff} + (AW+1)'(DEPTH) - {1'b0, sel_k});
      end

      state_in   = state_ff;
      rd_kind_in = RD_NONE;
      rd_k_in    = k_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      r_in       = r_ff;
      span_in    = span_ff;
      k_in       = k_ff;
      pos_in     = pos_ff;
      ctr_in     = ctr_ff;
      low_ok_in  = low_ok_ff;
      high_ok_in = high_ok_ff;
      tested_in  = tested_ff;
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = head_inc;
      mem_wdata.primary      = req_data.primary_sample;
      mem_wdata.primary_ok   = req_data.primary_ok;
      mem_wdata.secondary    = req_data.secondary_sample;
      mem_wdata.secondary_ok = req_data.secondary_ok;
      evt = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mem_we     = 1'b1;
               head_in    = head_inc;
               count_in   = count_inc;
               r_in       = r_clamp;
               span_in    = l_clamp + r_clamp;
               low_ok_in  = 1'b1;
               high_ok_in = 1'b1;
               if (count_inc >= 32'(l_clamp) + 32'(r_clamp) + 32'd1) begin
                  tested_in = 1'b1;
                  state_in  = ST_CENTER;
               end else begin
                  tested_in = 1'b0;
                  state_in  = ST_DECIDE;
               end
            end
         end
         ST_CENTER: begin
            rd_kind_in = RD_CENTER;
            pos_in     = count_ff - POS_W'(1) - POS_W'(r_ff);
            k_in       = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            rd_kind_in = RD_NEIGHBOR;
            rd_k_in    = k_ff;
            if (k_ff == span_ff) begin
               state_in = ST_LAST;
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Hold here while the previous result is still waiting.
            if (out_free) begin
               evt.fire         = 1'b1;
               evt.low          = tested_ff & ctr_ff.primary_ok & low_ok_ff;
               evt.high         = tested_ff & ctr_ff.primary_ok & high_ok_ff;
               evt.pos          = pos_ff;
               evt.primary      = ctr_ff.primary;
               evt.secondary    = ctr_ff.secondary;
               evt.secondary_ok = ctr_ff.secondary_ok;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Read data arrives in the cycle after its address.
      case (rd_kind_ff)
         RD_CENTER: begin
            ctr_in = mem_rdata;
         end
         RD_NEIGHBOR: begin
            // Skip the candidate itself and invalid neighbors.
            if (rd_k_ff != r_ff && mem_rdata.primary_ok) begin
               if ($signed(ctr_ff.primary) >= $signed(mem_rdata.primary)) begin
                  low_ok_in = 1'b0;
               end
               if ($signed(ctr_ff.primary) <= $signed(mem_rdata.primary)) begin
                  high_ok_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: hdl/pdd_track.sv
// Last pivot records, divergence test and the result register.
module pdd_track (
   input  logic                   clock,
   input  logic                   reset,
   input  pdd_pkg::pivot_evt_type evt,
   input  logic [15:0]            max_gap,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pdd_pkg::rsp_type       rsp_data
);
   import pdd_pkg::*;

   pivot_rec_type low_ff, low_in;
   pivot_rec_type high_ff, high_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   pivot_rec_type cur;
   logic [15:0]   gap_lim;

   function automatic logic near_prev(input pivot_rec_type prev, input pivot_rec_type c,
                                      input logic [15:0] lim);
      return prev.present && (c.pos > prev.pos) && c.secondary_ok && prev.secondary_ok &&
             ((c.pos - prev.pos) <= POS_W'(lim));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      gap_lim          = (max_gap == 16'd0) ? 16'd1 : max_gap;
      cur.present      = 1'b1;
      cur.pos          = evt.pos;
      cur.primary      = evt.primary;
      cur.secondary    = evt.secondary;
      cur.secondary_ok = evt.secondary_ok;
      out_free         = !rsp_valid_ff || rsp_ready;

      low_in       = low_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (evt.fire) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.low_found  = evt.low;
         rsp_data_in.high_found = evt.high;
         rsp_data_in.bullish    = evt.low && near_prev(low_ff, cur, gap_lim) &&
                                  ($signed(cur.primary) < $signed(low_ff.primary)) &&
                                  ($signed(cur.secondary) > $signed(low_ff.secondary));
         rsp_data_in.bearish    = evt.high && near_prev(high_ff, cur, gap_lim) &&
                                  ($signed(cur.primary) > $signed(high_ff.primary)) &&
                                  ($signed(cur.secondary) < $signed(high_ff.secondary));
         // A new pivot always replaces the previous one of its kind.
         if (evt.low) begin
            low_in = cur;
         end
         if (evt.high) begin
            high_in = cur;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/pivot_divergence_detector.sv
// Pivot high/low divergence detector: top level with configuration registers.
// One result per item. Every item is written into a ring memory of
// MAX_LEFT+MAX_RIGHT+1 entries; once left+right+1 items have arrived, the
// candidate right items back is read, then all left+right+1 window entries
// one per cycle through the single read port; a new item is taken only once
// the last one has left its final step. The scan of that one read port sets
// the rate. The result sits in an output register; a stalled result holds the
// block in its final step, not at input. Spans are clamped to 1..MAX_LEFT and
// 1..MAX_RIGHT, and a max_gap of zero acts as one. Span changes apply from the
// next item; a max_gap change applies from the next result.
module pivot_divergence_detector #(
   parameter int MAX_LEFT  = 32,
   parameter int MAX_RIGHT = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pdd_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pdd_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [pdd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pdd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pdd_pkg::*;

   localparam int DEPTH = MAX_LEFT + MAX_RIGHT + 1;
   localparam int AW    = $clog2(DEPTH);

   logic [5:0]    left_ff, left_in;
   logic [5:0]    right_ff, right_in;
   logic [15:0]   gap_ff, gap_in;
   logic          out_free, mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   win_entry_type mem_wdata, mem_rdata;
   pivot_evt_type evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= LEFT_SPAN_RESET;
         right_ff <= RIGHT_SPAN_RESET;
         gap_ff   <= MAX_GAP_RESET;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         gap_ff   <= gap_in;
      end
   end

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      gap_in   = gap_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LEFT_SPAN:  left_in  = csr_wdata[5:0];
            CSR_RIGHT_SPAN: right_in = csr_wdata[5:0];
            CSR_MAX_GAP:    gap_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pdd_window_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pdd_scan #(
      .MAX_LEFT  (MAX_LEFT),
      .MAX_RIGHT (MAX_RIGHT),
      .DEPTH     (DEPTH),
      .AW        (AW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .left_span  (left_ff),
      .right_span (right_ff),
      .out_free   (out_free),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .evt        (evt)
   );

   pdd_track u_track (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .max_gap   (gap_ff),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/pdd_checker.sv
// Port-level checks for the pivot divergence detector, bound to the top level.
module pdd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pdd_pkg::rsp_type rsp_data
);
   import pdd_pkg::*;

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Divergence only comes with a confirmed pivot of its kind.
   a_bull_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.bullish || rsp_data.low_found)
      else $error("bullish without pivot low");

   a_bear_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.bearish || rsp_data.high_found)
      else $error("bearish without pivot high");

   // One item at a time: no input taken in the cycle after an item.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted back to back");

endmodule

bind pivot_divergence_detector pdd_checker u_pdd_checker (.*);
